[design/qbnms_pkg.sv]
// Package: constants, types and the sigmoid table for the quad box suppression block.
package qbnms_pkg;

   localparam int MaxCandidates = 128;
   localparam int KeptIdxWidth = $clog2(MaxCandidates);
   localparam int KeptCntWidth = $clog2(MaxCandidates + 1);
   localparam int SigmoidDepth = 256;
   localparam int SigIdxWidth = $clog2(SigmoidDepth);

   typedef enum logic [1:0] {
      CSR_SCALE_X = 2'd0,
      CSR_SCALE_Y = 2'd1,
      CSR_THRESHOLD = 2'd2
   } csr_index_type;

   // Request as it leaves the front part
   typedef struct packed {
      logic [63:0] corner_xs;
      logic [63:0] corner_ys;
      logic [15:0] min_x;
      logic [15:0] max_x;
      logic [15:0] min_y;
      logic [15:0] max_y;
      logic [SigIdxWidth-1:0] sig_idx;
      logic [1:0] colour_index;
      logic [2:0] tag_index;
      logic check;
      logic last;
   } work_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } back_state_type;

   // Shift-subtract division, only used while building the table
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 64'd0;
      rem = 64'd0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Sigmoid of the bin centre, Q0.16. Computed at elaboration with the same
   // fixed point series as the definition.
   function automatic logic [15:0] sigmoid_entry(input int idx);
      longint unsigned exp_neg_int [8];
      longint centre;
      longint unsigned a;
      longint unsigned f;
      longint unsigned term;
      longint sum;
      longint unsigned e;
      longint unsigned den;
      longint unsigned r;
      int n;
      exp_neg_int[0] = 64'd4294967296;
      exp_neg_int[1] = 64'd1580030169;
      exp_neg_int[2] = 64'd581260616;
      exp_neg_int[3] = 64'd213833830;
      exp_neg_int[4] = 64'd78665070;
      exp_neg_int[5] = 64'd28939263;
      exp_neg_int[6] = 64'd10646159;
      exp_neg_int[7] = 64'd3916504;
      centre = longint'(((64'(2 * idx + 1)) << 27) / SigmoidDepth) - (64'sd1 <<< 27);
      a = (centre < 0) ? longint'(-centre) : longint'(centre);
      n = int'((a >> 24) & 64'd7);
      f = (a & 64'hFFFFFF) << 8;
      term = 64'd1 << 32;
      sum = longint'(term);
      for (int k = 1; k <= 13; k++) begin
         term = udiv64((term * f) >> 32, 64'(k));
         if ((k & 1) != 0) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      e = longint'(sum);
      if (e > (64'd1 << 32)) e = 64'd1 << 32;
      if (n != 0) begin
         if (e == (64'd1 << 32)) e = exp_neg_int[n];
         else e = (e * exp_neg_int[n]) >> 32;
      end
      den = (64'd1 << 32) + e;
      if (centre >= 0) r = udiv64(64'd1 << 48, den);
      else r = udiv64(e << 16, den);
      if (r > 64'd65535) r = 64'd65535;
      return r[15:0];
   endfunction

   typedef logic [15:0] sig_table_type [SigmoidDepth];

   function automatic sig_table_type build_sig_table();
      sig_table_type t;
      for (int i = 0; i < SigmoidDepth; i++) t[i] = sigmoid_entry(i);
      return t;
   endfunction

   localparam sig_table_type SigTable = build_sig_table();

endpackage

[design/quad_box_greedy_nms.sv]
// Top level of the quad box greedy suppression block.
//  channel | direction | handshake        | contents
//  req     | in        | push / full      | one candidate
//  rsp     | out       | pop / empty      | kept box or end of frame
//  csr     | in        | valid / ready    | index, 16-bit data
// A checked candidate is scanned against the kept table in the back part (one kept
// table read a cycle) and then scaled when kept.
// Reset is synchronous; the queue holds two candidates so the front keeps
// accepting while the back scans or waits on a full result register.
module quad_box_greedy_nms
   import qbnms_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [63:0] req_corner_xs,
   input  logic [63:0] req_corner_ys,
   input  logic signed [15:0] req_conf_logit,
   input  logic [63:0] req_colour_scores,
   input  logic [63:0] req_tag_scores_low,
   input  logic [47:0] req_tag_scores_high,
   input  logic req_last_candidate,
   output logic empty,
   input  logic pop,
   output logic [63:0] rsp_out_xs,
   output logic [63:0] rsp_out_ys,
   output logic [15:0] rsp_confidence,
   output logic [1:0] rsp_colour_index,
   output logic [2:0] rsp_tag_index,
   output logic rsp_box_present,
   output logic rsp_end_of_frame,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] scale_x_ff, scale_y_ff, thr_ff;
   logic fifo_push, fifo_full, fifo_empty, fifo_pop;
   work_type work, q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff <= 16'd4096;
         scale_y_ff <= 16'd4096;
         thr_ff <= 16'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCALE_X: scale_x_ff <= csr_data;
            CSR_SCALE_Y: scale_y_ff <= csr_data;
            CSR_THRESHOLD: thr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   qbnms_front u_front (
      .clock, .reset, .push, .full,
      .req_corner_xs, .req_corner_ys, .req_conf_logit, .req_colour_scores,
      .req_tag_scores_low, .req_tag_scores_high, .req_last_candidate,
      .threshold(thr_ff), .fifo_push, .fifo_full, .work
   );

   qbnms_fifo u_fifo (
      .clock, .reset, .wr_en(fifo_push), .wr_data(work), .full(fifo_full),
      .rd_en(fifo_pop), .empty(fifo_empty), .rd_data(q_data)
   );

   qbnms_back u_back (
      .clock, .reset, .q_empty(fifo_empty), .q_data, .q_pop(fifo_pop),
      .scale_x(scale_x_ff), .scale_y(scale_y_ff), .empty, .pop,
      .rsp_out_xs, .rsp_out_ys, .rsp_confidence, .rsp_colour_index,
      .rsp_tag_index, .rsp_box_present, .rsp_end_of_frame
   );

endmodule

[design/qbnms_front.sv]
// Front part: threshold check, box extents, argmax and sigmoid table index.
module qbnms_front
   import qbnms_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [63:0] req_corner_xs,
   input  logic [63:0] req_corner_ys,
   input  logic signed [15:0] req_conf_logit,
   input  logic [63:0] req_colour_scores,
   input  logic [63:0] req_tag_scores_low,
   input  logic [47:0] req_tag_scores_high,
   input  logic req_last_candidate,
   input  logic signed [15:0] threshold,
   output logic fifo_push,
   input  logic fifo_full,
   output work_type work
);

   logic below_ff, below_in;
   logic below_now;
   logic signed [15:0] xs [4];
   logic signed [15:0] ys [4];
   logic signed [15:0] cs [4];
   logic signed [15:0] ts [7];
   logic signed [15:0] clamp;
   logic [12:0] biased;
   logic [SigIdxWidth+12:0] scaled;

   assign full = fifo_full;
   assign fifo_push = push && !fifo_full;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         xs[k] = req_corner_xs[16*k +: 16];
         ys[k] = req_corner_ys[16*k +: 16];
         cs[k] = req_colour_scores[16*k +: 16];
         ts[k] = req_tag_scores_low[16*k +: 16];
      end
      for (int k = 0; k < 3; k++) ts[k+4] = req_tag_scores_high[16*k +: 16];
   end

   assign below_now = below_ff || (req_conf_logit < threshold);
   assign below_in = fifo_push ? (below_now && !req_last_candidate) : below_ff;

   always_ff @(posedge clock) begin
      if (reset) below_ff <= 1'b0;
      else below_ff <= below_in;
   end

   always_comb begin
      logic signed [15:0] lx, hx, ly, hy, bc, bt;
      logic [1:0] ci;
      logic [2:0] ti;
      lx = xs[0]; hx = xs[0]; ly = ys[0]; hy = ys[0];
      for (int k = 1; k < 4; k++) begin
         if (xs[k] < lx) lx = xs[k];
         if (xs[k] > hx) hx = xs[k];
         if (ys[k] < ly) ly = ys[k];
         if (ys[k] > hy) hy = ys[k];
      end
      bc = cs[0]; ci = 2'd0;
      for (int k = 1; k < 4; k++)
         if (cs[k] > bc) begin bc = cs[k]; ci = 2'(k); end
      bt = ts[0]; ti = 3'd0;
      for (int k = 1; k < 7; k++)
         if (ts[k] > bt) begin bt = ts[k]; ti = 3'(k); end
      work.min_x = lx;
      work.max_x = hx;
      work.min_y = ly;
      work.max_y = hy;
      work.colour_index = ci;
      work.tag_index = ti;
      work.sig_idx = scaled[12 +: SigIdxWidth];
      work.corner_xs = req_corner_xs;
      work.corner_ys = req_corner_ys;
      work.check = !below_now;
      work.last = req_last_candidate;
   end

   always_comb begin
      if (req_conf_logit < -16'sd2048) clamp = -16'sd2048;
      else if (req_conf_logit > 16'sd2047) clamp = 16'sd2047;
      else clamp = req_conf_logit;
      biased = 13'(clamp + 16'sd2048);
      scaled = (SigIdxWidth+13)'(biased) * (SigIdxWidth+13)'(SigmoidDepth);
   end

endmodule

[design/qbnms_fifo.sv]
// Two-entry queue between the front and back parts.
module qbnms_fifo
   import qbnms_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic wr_en,
   input  work_type wr_data,
   output logic full,
   input  logic rd_en,
   output logic empty,
   output work_type rd_data
);

   work_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign count_in = count_ff + 2'(wr_en) - 2'(rd_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (wr_en) wr_ptr_ff <= !wr_ptr_ff;
         if (rd_en) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

[design/qbnms_back.sv]
// Back part: scan of the kept table, store, scaling and result register.
module qbnms_back
   import qbnms_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  work_type q_data,
   output logic q_pop,
   input  logic [15:0] scale_x,
   input  logic [15:0] scale_y,
   output logic empty,
   input  logic pop,
   output logic [63:0] rsp_out_xs,
   output logic [63:0] rsp_out_ys,
   output logic [15:0] rsp_confidence,
   output logic [1:0] rsp_colour_index,
   output logic [2:0] rsp_tag_index,
   output logic rsp_box_present,
   output logic rsp_end_of_frame
);

   back_state_type state_ff, state_in;
   logic [63:0] kept_mem [MaxCandidates];
   logic [63:0] rd_data_ff;
   logic [KeptCntWidth-1:0] count_ff, count_in;
   logic [KeptCntWidth-1:0] scan_ff, scan_in;
   logic rd_valid_ff, rd_valid_in;
   logic hit_ff, hit_in;
   logic [2:0] corner_ff, corner_in;
   logic [63:0] ox_ff, ox_in, oy_ff, oy_in;
   logic full_ff, full_in;
   logic [63:0] r_xs_ff, r_ys_ff;
   logic [15:0] r_conf_ff;
   logic [1:0] r_ci_ff;
   logic [2:0] r_ti_ff;
   logic r_box_ff, r_eof_ff;
   logic store, hit_now, scan_done, load, kept;
   logic signed [15:0] lx, hx, ly, hy;
   logic signed [15:0] cx, cy;
   logic signed [31:0] px_ff, py_ff;
   logic [15:0] sx_sat, sy_sat;

   // Sweep reads entry scan, checks it in the next cycle.
   always_comb begin
      logic signed [15:0] ix0, ix1, iy0, iy1;
      lx = rd_data_ff[15:0];
      hx = rd_data_ff[31:16];
      ly = rd_data_ff[47:32];
      hy = rd_data_ff[63:48];
      ix0 = (lx > $signed(q_data.min_x)) ? lx : $signed(q_data.min_x);
      ix1 = (hx < $signed(q_data.max_x)) ? hx : $signed(q_data.max_x);
      iy0 = (ly > $signed(q_data.min_y)) ? ly : $signed(q_data.min_y);
      iy1 = (hy < $signed(q_data.max_y)) ? hy : $signed(q_data.max_y);
      hit_now = rd_valid_ff && (ix0 < ix1) && (iy0 < iy1);
   end

   assign hit_in = (state_ff == ST_IDLE) ? 1'b0 : (hit_ff || hit_now);
   assign scan_done = (scan_ff == count_ff) && !rd_valid_ff;
   assign kept = q_data.check && (count_ff != KeptCntWidth'(MaxCandidates)) && !hit_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!q_empty) state_in = ST_SCAN;
         ST_SCAN: if (scan_done || hit_ff || !q_data.check) begin
            if (kept) state_in = ST_EMIT;
            else if (!q_data.last) state_in = ST_IDLE;
            else if (!full_ff) state_in = ST_IDLE;
         end
         ST_EMIT: if (corner_ff == 3'd5 && !full_ff) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Scaling: multiply registered, round and saturate next cycle.
   assign cx = q_data.corner_xs[16*corner_ff[1:0] +: 16];
   assign cy = q_data.corner_ys[16*corner_ff[1:0] +: 16];

   function automatic logic [15:0] round_sat(input logic signed [31:0] p);
      logic signed [32:0] q;
      q = ($signed({p[31], p}) + 33'sd8192) >>> 14;
      if (q > 33'sd32767) return 16'h7FFF;
      if (q < -33'sd32768) return 16'h8000;
      return q[15:0];
   endfunction

   assign sx_sat = round_sat(px_ff);
   assign sy_sat = round_sat(py_ff);

   always_comb begin
      scan_in = scan_ff;
      rd_valid_in = 1'b0;
      corner_in = corner_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      store = 1'b0;
      load = 1'b0;
      q_pop = 1'b0;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            corner_in = '0;
         end
         ST_SCAN: begin
            if (scan_ff != count_ff && !hit_ff && !hit_now) begin
               rd_valid_in = 1'b1;
               scan_in = scan_ff + 1'b1;
            end
            if (scan_done || hit_ff || !q_data.check) begin
               if (kept) begin
                  store = 1'b1;
                  count_in = count_ff + 1'b1;
               end else if (!q_data.last) begin
                  q_pop = 1'b1;
               end else if (!full_ff) begin
                  load = 1'b1;
                  q_pop = 1'b1;
                  count_in = '0;
               end
            end
         end
         ST_EMIT: begin
            if (corner_ff < 3'd5) corner_in = corner_ff + 3'd1;
            // Product of corner k arrives at corner_ff k+1
            if (corner_ff >= 3'd1 && corner_ff <= 3'd4) begin
               ox_in = {sx_sat, ox_ff[63:16]};
               oy_in = {sy_sat, oy_ff[63:16]};
            end
            if (corner_ff == 3'd5 && !full_ff) begin
               load = 1'b1;
               q_pop = 1'b1;
               if (q_data.last) count_in = '0;
            end
         end
         default: ;
      endcase
   end

   assign full_in = load ? 1'b1 : (pop ? 1'b0 : full_ff);
   assign empty = !full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         scan_ff <= '0;
         rd_valid_ff <= 1'b0;
         hit_ff <= 1'b0;
         corner_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff <= scan_in;
         rd_valid_ff <= rd_valid_in;
         hit_ff <= hit_in;
         corner_ff <= corner_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store)
         kept_mem[count_ff[KeptIdxWidth-1:0]] <=
            {q_data.max_y, q_data.min_y, q_data.max_x, q_data.min_x};
      rd_data_ff <= kept_mem[scan_ff[KeptIdxWidth-1:0]];
   end

   always_ff @(posedge clock) begin
      px_ff <= cx * $signed({1'b0, scale_x});
      py_ff <= cy * $signed({1'b0, scale_y});
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      if (load) begin
         r_box_ff <= (state_ff == ST_EMIT);
         r_eof_ff <= q_data.last;
         if (state_ff == ST_EMIT) begin
            r_xs_ff <= ox_ff;
            r_ys_ff <= oy_ff;
            r_conf_ff <= SigTable[q_data.sig_idx];
            r_ci_ff <= q_data.colour_index;
            r_ti_ff <= q_data.tag_index;
         end else begin
            r_xs_ff <= '0;
            r_ys_ff <= '0;
            r_conf_ff <= '0;
            r_ci_ff <= '0;
            r_ti_ff <= '0;
         end
      end
   end

   assign rsp_out_xs = r_xs_ff;
   assign rsp_out_ys = r_ys_ff;
   assign rsp_confidence = r_conf_ff;
   assign rsp_colour_index = r_ci_ff;
   assign rsp_tag_index = r_ti_ff;
   assign rsp_box_present = r_box_ff;
   assign rsp_end_of_frame = r_eof_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= KeptCntWidth'(MaxCandidates))
      else $error("kept count beyond table");
   a_store_once: assert property (@(posedge clock) disable iff (reset)
      store |=> state_ff == ST_EMIT)
      else $error("store without emit");
   a_load_pops: assert property (@(posedge clock) disable iff (reset)
      load |-> q_pop && !full_ff)
      else $error("result loaded over waiting result");
`endif

endmodule

[verif/quad_box_greedy_nms_test.sv]
// Testbench for the quad box greedy suppression block: directed and random frames against a predictor.
module quad_box_greedy_nms_test;
   import qbnms_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 20000;
   localparam int DrainCycles = 300;

   typedef struct {
      logic [63:0] xs;
      logic [63:0] ys;
      logic [15:0] conf;
      logic [1:0] colour;
      logic [2:0] tag;
      logic box;
      logic eof;
   } box_result_type;

   // Predicts kept boxes per frame and checks them in order
   class nms_scoreboard;
      logic [15:0] scale_x = 16'd4096;
      logic [15:0] scale_y = 16'd4096;
      logic signed [15:0] threshold = '0;
      logic [63:0] kept_box [MaxCandidates];
      int kept_total = 0;
      bit below_seen = 0;
      box_result_type pending_boxes [$];
      int errors = 0;

      function automatic logic [15:0] scaled(logic signed [15:0] c, logic [15:0] s);
         longint p;
         longint q;
         p = longint'(c) * longint'({1'b0, s}) + 8192;
         q = p >>> 14;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         return q[15:0];
      endfunction

      function automatic logic [15:0] sigmoid(logic signed [15:0] logit);
         longint unsigned e_int [8];
         longint raw;
         longint unsigned bin;
         longint centre;
         longint unsigned mag;
         longint unsigned frac;
         longint unsigned term;
         longint acc;
         longint unsigned e;
         longint unsigned r;
         int whole;
         e_int = '{64'd4294967296, 64'd1580030169, 64'd581260616, 64'd213833830,
                   64'd78665070, 64'd28939263, 64'd10646159, 64'd3916504};
         raw = logit;
         if (raw < -2048) raw = -2048;
         if (raw > 2047) raw = 2047;
         bin = ((raw + 2048) * SigmoidDepth) >> 12;
         centre = longint'(((2 * bin + 1) << 27) / SigmoidDepth) - (longint'(1) << 27);
         mag = (centre < 0) ? -centre : centre;
         whole = int'((mag >> 24) & 7);
         frac = (mag & 64'hFFFFFF) << 8;
         term = 64'd1 << 32;
         acc = term;
         for (int k = 1; k <= 13; k++) begin
            term = ((term * frac) >> 32) / k;
            acc = (k % 2) ? acc - longint'(term) : acc + longint'(term);
         end
         if (acc < 0) acc = 0;
         e = acc;
         if (e > (64'd1 << 32)) e = 64'd1 << 32;
         if (whole != 0) e = (e == (64'd1 << 32)) ? e_int[whole] : (e * e_int[whole]) >> 32;
         r = (centre >= 0) ? (64'd1 << 48) / ((64'd1 << 32) + e)
                           : (e << 16) / ((64'd1 << 32) + e);
         if (r > 65535) r = 65535;
         return r[15:0];
      endfunction

      function void note_request(logic [63:0] xs, logic [63:0] ys, logic signed [15:0] logit,
                                 logic [63:0] col, logic [63:0] tlo, logic [47:0] thi,
                                 logic last);
         box_result_type res;
         logic signed [15:0] lx, hx, ly, hy, x, y, best;
         logic signed [15:0] tags [7];
         bit hit;
         res = '{default: '0};
         if (!below_seen && logit < threshold) below_seen = 1;
         if (!below_seen && kept_total < MaxCandidates) begin
            lx = xs[15:0]; hx = lx; ly = ys[15:0]; hy = ly;
            for (int k = 1; k < 4; k++) begin
               x = xs[16*k +: 16]; y = ys[16*k +: 16];
               if (x < lx) lx = x;
               if (x > hx) hx = x;
               if (y < ly) ly = y;
               if (y > hy) hy = y;
            end
            hit = 0;
            for (int i = 0; i < kept_total; i++) begin
               logic signed [15:0] ax0, ax1, ay0, ay1;
               ax0 = kept_box[i][15:0]; ax1 = kept_box[i][31:16];
               ay0 = kept_box[i][47:32]; ay1 = kept_box[i][63:48];
               if ((ax0 > lx ? ax0 : lx) < (ax1 < hx ? ax1 : hx) &&
                   (ay0 > ly ? ay0 : ly) < (ay1 < hy ? ay1 : hy)) hit = 1;
            end
            if (!hit) begin
               kept_box[kept_total] = {hy, ly, hx, lx};
               kept_total++;
               res.box = 1;
               for (int k = 0; k < 4; k++) begin
                  res.xs[16*k +: 16] = scaled(xs[16*k +: 16], scale_x);
                  res.ys[16*k +: 16] = scaled(ys[16*k +: 16], scale_y);
               end
               res.conf = sigmoid(logit);
               best = col[15:0];
               for (int k = 1; k < 4; k++)
                  if ($signed(col[16*k +: 16]) > best) begin
                     best = col[16*k +: 16];
                     res.colour = 2'(k);
                  end
               for (int k = 0; k < 4; k++) tags[k] = tlo[16*k +: 16];
               for (int k = 0; k < 3; k++) tags[k+4] = thi[16*k +: 16];
               best = tags[0];
               for (int k = 1; k < 7; k++)
                  if (tags[k] > best) begin
                     best = tags[k];
                     res.tag = 3'(k);
                  end
            end
         end
         if (res.box || last) begin
            res.eof = last;
            pending_boxes.push_back(res);
         end
         if (last) begin
            kept_total = 0;
            below_seen = 0;
         end
      endfunction

      function void check_result(box_result_type got);
         box_result_type want;
         if (pending_boxes.size() == 0) begin
            $display("%0t: result with nothing outstanding, xs %h", $realtime, got.xs);
            errors++;
            return;
         end
         want = pending_boxes.pop_front();
         if (got.xs !== want.xs) begin
            $display("%0t: out_xs exp %h got %h", $realtime, want.xs, got.xs); errors++;
         end
         if (got.ys !== want.ys) begin
            $display("%0t: out_ys exp %h got %h", $realtime, want.ys, got.ys); errors++;
         end
         if (got.conf !== want.conf) begin
            $display("%0t: confidence exp %h got %h", $realtime, want.conf, got.conf); errors++;
         end
         if (got.colour !== want.colour) begin
            $display("%0t: colour_index exp %0d got %0d", $realtime, want.colour, got.colour);
            errors++;
         end
         if (got.tag !== want.tag) begin
            $display("%0t: tag_index exp %0d got %0d", $realtime, want.tag, got.tag); errors++;
         end
         if (got.box !== want.box) begin
            $display("%0t: box_present exp %b got %b", $realtime, want.box, got.box); errors++;
         end
         if (got.eof !== want.eof) begin
            $display("%0t: end_of_frame exp %b got %b", $realtime, want.eof, got.eof); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic full;
   logic [63:0] req_corner_xs = '0;
   logic [63:0] req_corner_ys = '0;
   logic signed [15:0] req_conf_logit = '0;
   logic [63:0] req_colour_scores = '0;
   logic [63:0] req_tag_scores_low = '0;
   logic [47:0] req_tag_scores_high = '0;
   logic req_last_candidate = 0;
   logic empty;
   logic pop = 0;
   logic [63:0] rsp_out_xs;
   logic [63:0] rsp_out_ys;
   logic [15:0] rsp_confidence;
   logic [1:0] rsp_colour_index;
   logic [2:0] rsp_tag_index;
   logic rsp_box_present;
   logic rsp_end_of_frame;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   nms_scoreboard frame_board = new();
   bit send_idle = 1;
   bit take_idle = 1;
   bit hold_request = 0;
   int stall_cycles = 0;

   quad_box_greedy_nms DUT (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full)
            frame_board.note_request(req_corner_xs, req_corner_ys, req_conf_logit,
                                     req_colour_scores, req_tag_scores_low,
                                     req_tag_scores_high, req_last_candidate);
         if (pop && !empty)
            frame_board.check_result('{rsp_out_xs, rsp_out_ys, rsp_confidence,
                                       rsp_colour_index, rsp_tag_index,
                                       rsp_box_present, rsp_end_of_frame});
         if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= StallLimit) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Receiver: random pops, with one long hold-off on request
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            pop <= 0;
            repeat (500) @(posedge clock);
            hold_request = 0;
         end
         gap = take_idle ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            pop <= 0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1;
         do @(posedge clock); while (empty);
      end
   end

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
      case (idx)
         CSR_SCALE_X: frame_board.scale_x = value;
         CSR_SCALE_Y: frame_board.scale_y = value;
         default: frame_board.threshold = value;
      endcase
   endtask

   task automatic send_candidate(logic [63:0] xs, logic [63:0] ys, logic [15:0] logit,
                                 logic [63:0] col, logic [63:0] tlo, logic [47:0] thi,
                                 logic last);
      int gap;
      gap = send_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
      push <= 1;
      req_corner_xs <= xs;
      req_corner_ys <= ys;
      req_conf_logit <= logit;
      req_colour_scores <= col;
      req_tag_scores_low <= tlo;
      req_tag_scores_high <= thi;
      req_last_candidate <= last;
      do @(posedge clock); while (full);
   endtask

   // Settle before touching registers: a dropped request may still be in the scan
   task automatic drain;
      push <= 0;
      do @(posedge clock); while (frame_board.pending_boxes.size() != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [63:0] score_word();
      logic [63:0] w;
      case ($urandom_range(0, 3))
         0: w = {4{16'($urandom_range(0, 2)) - 16'd1}};
         1: for (int k = 0; k < 4; k++) w[16*k +: 16] = 16'($urandom_range(0, 3)) - 16'd1;
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   function automatic logic [63:0] corner_word(int base, int span);
      logic [63:0] w;
      for (int k = 0; k < 4; k++) w[16*k +: 16] = 16'(base + $urandom_range(0, span));
      return w;
   endfunction

   task automatic random_frame(int len, bit fill);
      logic [15:0] logit;
      logic [63:0] xs, ys;
      logit = 16'($urandom_range(0, 3000)) - 16'd500;
      for (int i = 0; i < len; i++) begin
         if (fill) begin
            // Disjoint boxes along x so the kept table overflows
            xs = corner_word(i * 100 - 14000, 60);
            ys = corner_word(-200, 300);
         end else if ($urandom_range(0, 9) == 0) begin
            xs = {$urandom, $urandom};
            ys = {$urandom, $urandom};
         end else begin
            xs = corner_word($urandom_range(0, 1200) - 200, $urandom_range(0, 400));
            ys = corner_word($urandom_range(0, 800) - 200, $urandom_range(0, 300));
         end
         if ($urandom_range(0, 19) == 0) logit = 16'($urandom);
         else logit = logit - 16'($urandom_range(0, 120));
         send_candidate(xs, ys, logit, score_word(), score_word(),
                        48'(score_word()), i == len - 1);
      end
   endtask

   initial begin
      logic [15:0] sx [6];
      logic [15:0] sy [6];
      logic [15:0] th [6];
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed frames: extreme corners, overlap, touching and flat boxes, ties
      send_candidate({4{16'h8000}} | 64'h7FFF_0000_7FFF_0000, 64'h8000_7FFF_8000_7FFF,
                     16'sh7FFF, 64'h0, 64'h0, 48'h0, 0);
      send_candidate(64'h0000_0010_0000_0010, 64'h0000_0010_0000_0010, 16'sd900,
                     64'h7FFF_0000_0000_0000, 64'h0, 48'h7FFF_0000_0000, 0);
      drain();
      write_csr(CSR_SCALE_X, 16'd4096);
      send_candidate(64'h0, 64'h0, 16'sd800, 64'h8000_8000_8000_8000, 64'hFFFF, 48'h1, 1);
      send_candidate(64'h0000_0010_0000_0010, 64'h0000_0010_0000_0010, 16'sd700,
                     64'h0001_0002_0002_0001, 64'h0005_0005_0005_0005,
                     48'h0005_0005_0005, 0);
      send_candidate(64'h0020_0010_0020_0010, 64'h0000_0010_0000_0010, 16'sd600,
                     64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_0000_0000_0000, 48'h7FFF_0000_0000, 0);
      send_candidate(64'h0005_0005_0005_0005, 64'h0000_0010_0000_0010, 16'sd500,
                     64'h0, 64'h0, 48'h0, 0);
      send_candidate(64'h000F_0001_000F_0001, 64'h000F_0001_000F_0001, 16'sd400,
                     64'h0, 64'h0, 48'h0, 0);
      send_candidate(64'h0100_0200_0100_0200, 64'h0100_0200_0100_0200, 16'sh8000,
                     64'h0, 64'h0, 48'h0, 0);
      send_candidate(64'h0500_0600_0500_0600, 64'h0500_0600_0500_0600, 16'sd300,
                     64'h0, 64'h0, 48'h0, 1);
      send_candidate(64'h0300_0400_0300_0400, 64'h0300_0400_0300_0400, 16'sh8000,
                     64'h0, 64'h0, 48'h0, 1);
      send_candidate(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'sd0,
                     {4{16'h7FFF}}, {4{16'h8000}}, {3{16'h7FFF}}, 1);
      drain();

      sx = '{16'd65535, 16'd0, 16'd4096, 16'($urandom), 16'd8192, 16'($urandom)};
      sy = '{16'd0, 16'd65535, 16'($urandom), 16'd4096, 16'd2048, 16'($urandom)};
      th = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFE00, 16'($urandom_range(0, 1200)),
             16'($urandom)};
      for (int phase = 0; phase < 6; phase++) begin
         write_csr(CSR_SCALE_X, sx[phase]);
         write_csr(CSR_SCALE_Y, sy[phase]);
         write_csr(CSR_THRESHOLD, th[phase]);
         send_idle = (phase != 2);
         take_idle = (phase != 2 && phase != 4);
         if (phase == 1) hold_request = 1;
         if (phase == 0 || phase == 3) random_frame(135, 1);
         for (int n = 0; n < 250; ) begin
            int len;
            len = $urandom_range(1, 20);
            random_frame(len, 0);
            n += len;
         end
         drain();
      end

      if (frame_board.errors == 0 && frame_board.pending_boxes.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
